[rtl/core/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types, field widths and limits of the sparse polynomial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

	localparam int MODE_W      = 2;
	localparam int COEF_W      = 16;
	localparam int EXP_IN_W    = 4;
	localparam int PCOEF_W     = 35;
	localparam int PEXP_W      = 5;
	localparam int MUL_W       = 2 * COEF_W;

	localparam int MAX_TERMS_DEF = 8;
	localparam int MAX_POWER_DEF = 15;

	localparam logic signed [PCOEF_W-1:0] SUM_MAX = {1'b0, {(PCOEF_W-1){1'b1}}};
	localparam logic signed [PCOEF_W-1:0] SUM_MIN = {1'b1, {(PCOEF_W-1){1'b0}}};

	typedef enum logic [MODE_W-1:0] {
		MODE_FIRST  = 2'd0,
		MODE_SECOND = 2'd1,
		MODE_FINISH = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SCAN,
		ST_FLUSH,
		ST_EMPTY
	} state_t;

	// Control of one term store.
	typedef struct packed {
		logic load;
		logic clear;
	} ts_ctrl_t;

	// Index width of a store with n entries, at least one bit.
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

`default_nettype wire

[rtl/core/sparse_polynomial_multiply_unit.sv]
// ----------------------------------------------------------------------------
// sparse_polynomial_multiply_unit
// Multiplies two sparse polynomials loaded term by term and streams the
// product terms out, highest exponent first.
// ----------------------------------------------------------------------------
// Load transactions (mode 0 and 1) are taken one per cycle while the unit
// is idle. A finish transaction runs a multiply-accumulate pass over every
// pair of first and second terms, one product per cycle read-modify-written
// into a sum memory of 2*MAX_POWER+1 entries with one read and one write
// port, then drains the accumulate pipeline, then scans that memory from
// the top entry down, pausing while the output holds a result, and emits
// each present exponent and clears the entry behind it, then closes the
// scan and emits the final term. An empty product gives a single result
// flagged empty_product. After reset the sum memory is swept clear, during
// which no transaction is taken. The input stalls from the finish until its
// last result is registered at the output.
`default_nettype none

module sparse_polynomial_multiply_unit #(
	parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF,
	parameter int MAX_POWER = spm_pkg::MAX_POWER_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [spm_pkg::MODE_W-1:0]           mode,
	input  wire logic signed [spm_pkg::COEF_W-1:0]    coefficient,
	input  wire logic [spm_pkg::EXP_IN_W-1:0]         exponent,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [spm_pkg::PCOEF_W-1:0]        product_coefficient,
	output logic [spm_pkg::PEXP_W-1:0]                product_exponent,
	output logic                                      last_term,
	output logic                                      empty_product,
	output logic                                      terms_dropped
);
	import spm_pkg::*;

	localparam int IDX_W   = idx_w(MAX_TERMS);
	localparam int CNT_W   = $clog2(MAX_TERMS + 1);
	localparam int EXP_W   = $clog2(MAX_POWER + 1);
	localparam int NUM_EXP = 2 * MAX_POWER + 1;
	localparam int PE_W    = $clog2(NUM_EXP);
	localparam int ACC_W   = MUL_W + 1 + 2 * $clog2(MAX_TERMS);
	localparam int ENT_W   = ACC_W + 1;
	localparam int EXT_W   = (ACC_W > PCOEF_W) ? ACC_W : PCOEF_W;

	state_t state_q, state_d;

	// term stores
	ts_ctrl_t                 ctrl_a, ctrl_b;
	logic signed [COEF_W-1:0] coef_a, coef_b;
	logic [EXP_W-1:0]         exp_a, exp_b;
	logic [CNT_W-1:0]         first_count, second_count;
	logic                     drop_a, drop_b;
	logic                     overflow_q;

	// control strobes
	logic in_accept;
	logic mac_issue, scan_issue, flush, empty, job_done, arrive_hit, out_load;
	logic i_last, j_last;

	// accumulate pipeline
	logic [IDX_W-1:0]          i_q, j_q;
	logic                      mac_v_s1, mac_v_s2;
	logic [PE_W-1:0]           pe_s1, pe_s2;
	logic signed [MUL_W-1:0]   prod_s1, prod_s2;
	logic                      fwd_s2;
	logic signed [ACC_W-1:0]   wsum_q, acc_base, acc_new;

	// sum memory
	logic [ENT_W-1:0]          sum_mem [NUM_EXP];
	logic [ENT_W-1:0]          sum_rd_q;
	logic [PE_W-1:0]           sum_raddr, sum_waddr;
	logic [ENT_W-1:0]          sum_wdata;
	logic                      sum_we;
	logic [PE_W-1:0]           clr_q;

	// scan
	logic [PE_W-1:0]           k_q, k_s1;
	logic                      scan_done_q, rd_v_s1;
	logic                      pend_v_q;
	logic signed [PCOEF_W-1:0] pend_coef_q, sat_coef;
	logic [PEXP_W-1:0]         pend_exp_q;
	logic signed [EXT_W-1:0]   acc_ext;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign ctrl_a.load  = in_accept && (mode == MODE_FIRST);
	assign ctrl_b.load  = in_accept && (mode == MODE_SECOND);
	assign ctrl_a.clear = job_done;
	assign ctrl_b.clear = job_done;

	spm_term_store #(
		.MAX_TERMS(MAX_TERMS),
		.MAX_POWER(MAX_POWER)
	) u_first (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_a),
		.wr_coef (coefficient),
		.wr_exp  (exponent),
		.rd_addr (i_q),
		.rd_coef (coef_a),
		.rd_exp  (exp_a),
		.count   (first_count),
		.dropped (drop_a)
	);

	spm_term_store #(
		.MAX_TERMS(MAX_TERMS),
		.MAX_POWER(MAX_POWER)
	) u_second (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_b),
		.wr_coef (coefficient),
		.wr_exp  (exponent),
		.rd_addr (j_q),
		.rd_coef (coef_b),
		.rd_exp  (exp_b),
		.count   (second_count),
		.dropped (drop_b)
	);

	assign i_last = ((CNT_W'(i_q) + CNT_W'(1)) == first_count);
	assign j_last = ((CNT_W'(j_q) + CNT_W'(1)) == second_count);

	// ---------------------------------------------------------------- FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mac_issue  = 1'b0;
		scan_issue = 1'b0;
		flush      = 1'b0;
		empty      = 1'b0;
		job_done   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == PE_W'(NUM_EXP - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_accept && mode == MODE_FINISH) begin
					if (first_count == '0 || second_count == '0) state_d = ST_EMPTY;
					else state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				mac_issue = 1'b1;
				if (i_last && j_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!mac_v_s1 && !mac_v_s2) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				scan_issue = !scan_done_q && !rd_v_s1 && !out_valid;
				if (scan_done_q && !rd_v_s1) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!out_valid) begin
					flush    = 1'b1;
					job_done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (!out_valid) begin
					empty    = 1'b1;
					job_done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= 1'b0;
		end else if (job_done) begin
			overflow_q <= 1'b0;
		end else if (drop_a || drop_b) begin
			overflow_q <= 1'b1;
		end
	end

	// ------------------------------------------------- accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			j_q      <= '0;
			mac_v_s1 <= 1'b0;
			mac_v_s2 <= 1'b0;
			clr_q    <= '0;
		end else begin
			mac_v_s1 <= mac_issue;
			mac_v_s2 <= mac_v_s1;
			if (state_q == ST_CLEAR) clr_q <= clr_q + PE_W'(1);
			if (state_q == ST_IDLE) begin
				i_q <= '0;
				j_q <= '0;
			end else if (mac_issue) begin
				if (j_last) begin
					j_q <= '0;
					if (!i_last) i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

	assign pe_s1   = PE_W'(exp_a) + PE_W'(exp_b);
	assign prod_s1 = MUL_W'(coef_a) * MUL_W'(coef_b);

	always_ff @(posedge clk) begin
		pe_s2   <= pe_s1;
		prod_s2 <= prod_s1;
		// the write in flight is not yet visible to this read: take it from wsum_q
		fwd_s2  <= mac_v_s1 && mac_v_s2 && (pe_s1 == pe_s2);
		if (mac_v_s2) wsum_q <= acc_new;
	end

	assign acc_base = fwd_s2 ? wsum_q : sum_rd_q[ACC_W-1:0];
	assign acc_new  = acc_base + ACC_W'(prod_s2);

	// ---------------------------------------------------------- sum memory
	assign sum_raddr = (state_q == ST_SCAN) ? k_q : pe_s1;

	always_comb begin
		sum_we    = 1'b0;
		sum_waddr = k_q;
		sum_wdata = '0;
		if (state_q == ST_CLEAR) begin
			sum_we    = 1'b1;
			sum_waddr = clr_q;
		end else if (mac_v_s2) begin
			sum_we    = 1'b1;
			sum_waddr = pe_s2;
			sum_wdata = {1'b1, acc_new};
		end else if (scan_issue) begin
			// clear the entry behind the scan for the next job
			sum_we    = 1'b1;
			sum_waddr = k_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
		sum_rd_q <= sum_mem[sum_raddr];
	end

	// ---------------------------------------------------------------- scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			scan_done_q <= 1'b0;
			rd_v_s1     <= 1'b0;
		end else begin
			rd_v_s1 <= scan_issue;
			if (state_q == ST_DRAIN) begin
				k_q         <= PE_W'(NUM_EXP - 1);
				scan_done_q <= 1'b0;
			end else if (scan_issue) begin
				k_q <= k_q - PE_W'(1);
				if (k_q == '0) scan_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q;
	end

	assign acc_ext  = EXT_W'($signed(sum_rd_q[ACC_W-1:0]));
	assign sat_coef = (acc_ext > EXT_W'(SUM_MAX)) ? SUM_MAX :
	                  (acc_ext < EXT_W'(SUM_MIN)) ? SUM_MIN : PCOEF_W'(acc_ext);

	assign arrive_hit = rd_v_s1 && sum_rd_q[ENT_W-1];
	assign out_load   = (arrive_hit && pend_v_q) || flush || empty;

	// hold the latest hit until the next one shows it was not the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (arrive_hit) begin
			pend_v_q <= 1'b1;
		end else if (flush) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (arrive_hit) begin
			pend_coef_q <= sat_coef;
			pend_exp_q  <= PEXP_W'(k_s1);
		end
	end

	// ------------------------------------------------------ output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (empty) begin
			product_coefficient <= '0;
			product_exponent    <= '0;
			last_term           <= 1'b0;
			empty_product       <= 1'b1;
			terms_dropped       <= 1'b0;
		end else if (out_load) begin
			product_coefficient <= pend_coef_q;
			product_exponent    <= pend_exp_q;
			last_term           <= flush;
			empty_product       <= 1'b0;
			terms_dropped       <= overflow_q;
		end
	end

	// ----------------------------------------------------------- assertions
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid)
		else $error("output loaded while holding a transaction");

	a_scan_after_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (!mac_v_s1 && !mac_v_s2))
		else $error("scan overlaps accumulate writes");

	a_mac_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (CNT_W'(i_q) < first_count && CNT_W'(j_q) < second_count))
		else $error("term index beyond store count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_count <= CNT_W'(MAX_TERMS) && second_count <= CNT_W'(MAX_TERMS))
		else $error("term count beyond capacity");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_product) |->
			(product_coefficient == '0 && !last_term && !terms_dropped))
		else $error("empty product carries data");

endmodule

`default_nettype wire

[rtl/core/spm_term_store.sv]
// ----------------------------------------------------------------------------
// spm_term_store
// Bounded store of polynomial terms: appends a term per load, saturates the
// exponent, flags a load into a full store, gives registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_term_store #(
	parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF,
	parameter int MAX_POWER = spm_pkg::MAX_POWER_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire spm_pkg::ts_ctrl_t                             ctrl,
	input  wire logic signed [spm_pkg::COEF_W-1:0]             wr_coef,
	input  wire logic [spm_pkg::EXP_IN_W-1:0]                  wr_exp,
	input  wire logic [spm_pkg::idx_w(MAX_TERMS)-1:0]          rd_addr,
	output logic signed [spm_pkg::COEF_W-1:0]                  rd_coef,
	output logic [$clog2(MAX_POWER+1)-1:0]                     rd_exp,
	output logic [$clog2(MAX_TERMS+1)-1:0]                     count,
	output logic                                               dropped
);
	import spm_pkg::*;

	localparam int IDX_W = idx_w(MAX_TERMS);
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int EXP_W = $clog2(MAX_POWER + 1);

	logic signed [COEF_W-1:0] coef_mem [MAX_TERMS];
	logic [EXP_W-1:0]         exp_mem  [MAX_TERMS];
	logic [CNT_W-1:0]         count_q;
	logic                     full;
	logic                     wr_en;
	logic [EXP_W-1:0]         exp_sat;

	assign full    = (count_q == CNT_W'(MAX_TERMS));
	assign wr_en   = ctrl.load && !full;
	assign dropped = ctrl.load && full;
	assign count   = count_q;
	assign exp_sat = (32'(wr_exp) > MAX_POWER) ? EXP_W'(MAX_POWER) : EXP_W'(wr_exp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coef_mem[count_q[IDX_W-1:0]] <= wr_coef;
			exp_mem[count_q[IDX_W-1:0]]  <= exp_sat;
		end
		rd_coef <= coef_mem[rd_addr];
		rd_exp  <= exp_mem[rd_addr];
	end

endmodule

`default_nettype wire
